FILE: rtl/gbc_pkg.sv
package gbc_pkg;

    // default grid limits
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 4096;

    // register and field widths
    localparam int COLS_W  = 11;
    localparam int ROWS_W  = 13;
    localparam int COUNT_W = 26;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // register reset values
    localparam logic [COLS_W-1:0]  RST_GRID_COLS      = COLS_W'(1024);
    localparam logic [ROWS_W-1:0]  RST_GRID_ROWS      = ROWS_W'(1024);
    localparam logic [COUNT_W-1:0] RST_PAIR_THRESHOLD = '0;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // register indexes, at byte address 4*index
    typedef enum logic [1:0] {
        REG_GRID_COLS      = 2'd0,
        REG_GRID_ROWS      = 2'd1,
        REG_PAIR_THRESHOLD = 2'd2
    } reg_idx_t;

    // clamped geometry and threshold in use
    typedef struct packed {
        logic [COLS_W-1:0]  cols;
        logic [ROWS_W-1:0]  rows;
        logic [COUNT_W-1:0] threshold;
    } geom_t;

    // one cell as kept in the line buffer
    typedef struct packed {
        logic from_first;
        logic usable;
    } cell_t;

    // where the current cell sits in the raster
    typedef struct packed {
        logic first_col;
        logic first_row;
        logic last_col;
        logic last_row;
    } pos_t;

endpackage

FILE: rtl/grid_boundary_contact_counter.sv
// Grid boundary contact counter. Cells arrive one per transfer in raster
// order (all columns of row 0, then row 1, ...) with the grid size taken from
// grid_cols and grid_rows, clamped to 1..MAX_COLS and 1..MAX_ROWS. A cell is
// usable when occupied and not an obstacle; each usable cell is compared with
// its left, up-left, up and up-right neighbours and every usable neighbour
// from the other map adds 2 to a count that saturates at 2^26-1. The cell in
// the last row and column produces one result transfer carrying the count and
// whether it exceeds pair_threshold, then the count restarts. One cell is
// taken every clock; the previous row sits in a line buffer of MAX_COLS
// entries with two read ports, read one cell ahead so the neighbours are ready
// when a cell arrives. The input stalls only on a frame's last cell while the
// previous result has not been taken. Configuration must be written only while idle; the block does not enforce this.
module grid_boundary_contact_counter #(
    parameter int MAX_COLS = gbc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gbc_pkg::DEF_MAX_ROWS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gbc_pkg::ADDR_W-1:0]   paddr,
    input  logic [gbc_pkg::DATA_W-1:0]   pwdata,
    output logic [gbc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // cell input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_occupied,
    input  logic                         s_from_first,
    input  logic                         s_obstacle,
    // result output
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gbc_pkg::COUNT_W-1:0]  m_pair_count,
    output logic                         m_connected
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    gbc_pkg::geom_t      geom;
    gbc_pkg::pos_t       pos;
    gbc_pkg::cell_t      cur;
    gbc_pkg::cell_t      up_raw;
    gbc_pkg::cell_t      up_right_raw;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [COL_W-1:0]    rd_addr_a;
    logic [COL_W-1:0]    rd_addr_b;
    logic                accept;

    gbc_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom)
    );

    // raster position flags
    always_comb begin
        pos.first_col = (col_reg == '0);
        pos.first_row = (row_reg == '0);
        pos.last_col  = (32'(col_reg) + 32'd1 >= 32'(geom.cols));
        pos.last_row  = (32'(row_reg) + 32'd1 >= 32'(geom.rows));
    end

    assign cur.usable     = s_occupied && !s_obstacle;
    assign cur.from_first = s_from_first;

    // hold off the frame's last cell while a result is still pending
    assign s_ready = !(m_valid && !m_ready && pos.last_col && pos.last_row);
    assign accept  = s_valid && s_ready;

    // next raster position
    always_comb begin
        if (pos.last_col) begin
            col_next = '0;
            row_next = pos.last_row ? '0 : row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // read up and up-right of the cell that will be current next cycle
    assign rd_addr_a = accept ? col_next : col_reg;
    assign rd_addr_b = rd_addr_a + COL_W'(1);

    gbc_line_buf #(
        .MAX_COLS (MAX_COLS)
    ) u_line_buf (
        .aclk      (aclk),
        .wr_en     (accept),
        .wr_addr   (col_reg),
        .wr_data   (cur),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (up_raw),
        .rd_data_b (up_right_raw)
    );

    gbc_tally u_tally (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .cur          (cur),
        .up_raw       (up_raw),
        .up_right_raw (up_right_raw),
        .pos          (pos),
        .threshold    (geom.threshold),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pair_count (m_pair_count),
        .m_connected  (m_connected)
    );

endmodule

FILE: rtl/gbc_cfg.sv
module gbc_cfg #(
    parameter int MAX_COLS = gbc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gbc_pkg::DEF_MAX_ROWS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbc_pkg::ADDR_W-1:0]  paddr,
    input  logic [gbc_pkg::DATA_W-1:0]  pwdata,
    output logic [gbc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output gbc_pkg::geom_t              geom
);

    logic [gbc_pkg::COLS_W-1:0]  grid_cols_reg;
    logic [gbc_pkg::ROWS_W-1:0]  grid_rows_reg;
    logic [gbc_pkg::COUNT_W-1:0] pair_threshold_reg;
    gbc_pkg::reg_idx_t           idx;
    logic                        wr_en;

    assign pready = 1'b1;
    assign idx    = gbc_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg      <= gbc_pkg::RST_GRID_COLS;
            grid_rows_reg      <= gbc_pkg::RST_GRID_ROWS;
            pair_threshold_reg <= gbc_pkg::RST_PAIR_THRESHOLD;
        end else if (wr_en) begin
            unique case (idx)
                gbc_pkg::REG_GRID_COLS:
                    grid_cols_reg <= pwdata[gbc_pkg::COLS_W-1:0];
                gbc_pkg::REG_GRID_ROWS:
                    grid_rows_reg <= pwdata[gbc_pkg::ROWS_W-1:0];
                gbc_pkg::REG_PAIR_THRESHOLD:
                    pair_threshold_reg <= pwdata[gbc_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (idx)
            gbc_pkg::REG_GRID_COLS:      prdata = gbc_pkg::DATA_W'(grid_cols_reg);
            gbc_pkg::REG_GRID_ROWS:      prdata = gbc_pkg::DATA_W'(grid_rows_reg);
            gbc_pkg::REG_PAIR_THRESHOLD: prdata = gbc_pkg::DATA_W'(pair_threshold_reg);
            default:                     prdata = '0;
        endcase
    end

    // clamp geometry to 1..max
    always_comb begin
        priority if (grid_cols_reg == '0)
            geom.cols = gbc_pkg::COLS_W'(1);
        else if (32'(grid_cols_reg) > 32'(MAX_COLS))
            geom.cols = gbc_pkg::COLS_W'(MAX_COLS);
        else
            geom.cols = grid_cols_reg;

        priority if (grid_rows_reg == '0)
            geom.rows = gbc_pkg::ROWS_W'(1);
        else if (32'(grid_rows_reg) > 32'(MAX_ROWS))
            geom.rows = gbc_pkg::ROWS_W'(MAX_ROWS);
        else
            geom.rows = grid_rows_reg;

        geom.threshold = pair_threshold_reg;
    end

endmodule

FILE: rtl/gbc_line_buf.sv
module gbc_line_buf #(
    parameter int MAX_COLS = gbc_pkg::DEF_MAX_COLS,
    localparam int COL_W   = $clog2(MAX_COLS)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [COL_W-1:0]     wr_addr,
    input  gbc_pkg::cell_t       wr_data,
    input  logic [COL_W-1:0]     rd_addr_a,
    input  logic [COL_W-1:0]     rd_addr_b,
    output gbc_pkg::cell_t       rd_data_a,
    output gbc_pkg::cell_t       rd_data_b
);

    gbc_pkg::cell_t mem [MAX_COLS];
    gbc_pkg::cell_t rd_a_reg;
    gbc_pkg::cell_t rd_b_reg;

    // previous row store, writes forwarded to a read of the same entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
        rd_b_reg <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: rtl/gbc_tally.sv
module gbc_tally (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  gbc_pkg::cell_t               cur,
    input  gbc_pkg::cell_t               up_raw,
    input  gbc_pkg::cell_t               up_right_raw,
    input  gbc_pkg::pos_t                pos,
    input  logic [gbc_pkg::COUNT_W-1:0]  threshold,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gbc_pkg::COUNT_W-1:0]  m_pair_count,
    output logic                         m_connected
);

    gbc_pkg::cell_t              left_reg;
    gbc_pkg::cell_t              up_left_reg;
    logic [gbc_pkg::COUNT_W-1:0] count_reg;
    logic [gbc_pkg::COUNT_W-1:0] count_next;
    logic                        m_valid_reg;
    logic [gbc_pkg::COUNT_W-1:0] pair_count_reg;
    logic                        connected_reg;

    gbc_pkg::cell_t              left;
    gbc_pkg::cell_t              up_left;
    gbc_pkg::cell_t              up;
    gbc_pkg::cell_t              up_right;
    logic [2:0]                  hits;
    logic [gbc_pkg::COUNT_W:0]   sum;

    function automatic logic contact(gbc_pkg::cell_t a, gbc_pkg::cell_t b);
        return a.usable && b.usable && (a.from_first != b.from_first);
    endfunction

    // neighbours outside the grid read as empty
    always_comb begin
        up       = pos.first_row ? '0 : up_raw;
        up_right = (pos.first_row || pos.last_col) ? '0 : up_right_raw;
        left     = pos.first_col ? '0 : left_reg;
        up_left  = pos.first_col ? '0 : up_left_reg;
    end

    // count cross-map contacts, two per match, saturating
    always_comb begin
        hits = 3'(contact(cur, left)) + 3'(contact(cur, up_left))
             + 3'(contact(cur, up)) + 3'(contact(cur, up_right));
        sum  = (gbc_pkg::COUNT_W+1)'(count_reg)
             + (gbc_pkg::COUNT_W+1)'({hits, 1'b0});
        count_next = sum[gbc_pkg::COUNT_W] ? gbc_pkg::COUNT_MAX
                                           : sum[gbc_pkg::COUNT_W-1:0];
    end

    // neighbour window and running count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg    <= '0;
            up_left_reg <= '0;
            count_reg   <= '0;
        end else if (accept) begin
            left_reg    <= cur;
            up_left_reg <= up;
            count_reg   <= (pos.last_col && pos.last_row) ? '0 : count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && pos.last_col && pos.last_row) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (accept && pos.last_col && pos.last_row) begin
            pair_count_reg <= count_next;
            connected_reg  <= (count_next > threshold);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pair_count = pair_count_reg;
    assign m_connected  = connected_reg;

endmodule

FILE: bench/contact_count_checker.sv
`timescale 1ns / 100ps

module contact_count_checker #(
    parameter int MAX_COLS = gbc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gbc_pkg::DEF_MAX_ROWS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [gbc_pkg::ADDR_W-1:0]  paddr,
    input  logic [gbc_pkg::DATA_W-1:0]  pwdata,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_occupied,
    input  logic                        s_from_first,
    input  logic                        s_obstacle,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [gbc_pkg::COUNT_W-1:0] m_pair_count,
    input  logic                        m_connected,
    output int                          mismatches,
    output int                          tallies_pending,
    output int                          frames_checked
);

    typedef struct packed {
        logic [gbc_pkg::COUNT_W-1:0] count;
        logic                        connected;
    } frame_tally_t;

    // register copies, picked up from the configuration bus
    logic [gbc_pkg::COLS_W-1:0]  cols_reg;
    logic [gbc_pkg::ROWS_W-1:0]  rows_reg;
    logic [gbc_pkg::COUNT_W-1:0] threshold_reg;

    // raster state
    gbc_pkg::cell_t              prior_row [MAX_COLS];
    gbc_pkg::cell_t              left_nb;
    gbc_pkg::cell_t              up_left_nb;
    int unsigned                 col_at;
    int unsigned                 row_at;
    logic [gbc_pkg::COUNT_W-1:0] running_tally;

    frame_tally_t       expected_tallies [$];
    int                 fail_tally;
    int                 match_tally;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // two per usable neighbour from the other map
    function automatic int unsigned cross_gain(gbc_pkg::cell_t a, gbc_pkg::cell_t b);
        return (a.usable && b.usable && (a.from_first != b.from_first)) ? 2 : 0;
    endfunction

    // advance the raster by one cell, queue the frame total on its last cell
    task automatic tally_cell(input logic occ, input logic ff, input logic obs);
        int unsigned                 cols;
        int unsigned                 rows;
        int unsigned                 c;
        int unsigned                 r;
        int unsigned                 gain;
        logic                        end_col;
        logic                        end_row;
        gbc_pkg::cell_t              cur;
        gbc_pkg::cell_t              up;
        gbc_pkg::cell_t              up_right;
        logic [gbc_pkg::COUNT_W:0]   sum;
        frame_tally_t                done;
        cols     = clamp_size(int'(cols_reg), MAX_COLS);
        rows     = clamp_size(int'(rows_reg), MAX_ROWS);
        c        = col_at;
        r        = row_at;
        end_col  = (c + 1 >= cols);
        end_row  = (r + 1 >= rows);
        cur.usable     = occ && !obs;
        cur.from_first = ff;
        up       = '0;
        up_right = '0;
        gain     = 0;
        if (c >= MAX_COLS) c = MAX_COLS - 1;
        if (r > 0) begin
            up = prior_row[c];
            if (!end_col) up_right = prior_row[c + 1];
        end
        if (cur.usable) begin
            if (c > 0) gain += cross_gain(cur, left_nb);
            if (r > 0) begin
                if (c > 0) gain += cross_gain(cur, up_left_nb);
                gain += cross_gain(cur, up);
                if (!end_col) gain += cross_gain(cur, up_right);
            end
        end
        sum = {1'b0, running_tally} + (gbc_pkg::COUNT_W + 1)'(gain);
        running_tally = (sum > {1'b0, gbc_pkg::COUNT_MAX}) ? gbc_pkg::COUNT_MAX
                                                           : sum[gbc_pkg::COUNT_W-1:0];
        up_left_nb   = up;
        prior_row[c] = cur;
        left_nb      = cur;
        if (end_col) begin
            col_at = 0;
            if (end_row) begin
                done.count     = running_tally;
                done.connected = (running_tally > threshold_reg);
                expected_tallies.push_back(done);
                running_tally = '0;
                row_at        = 0;
            end else begin
                row_at = r + 1;
            end
        end else begin
            col_at = c + 1;
        end
    endtask

    always @(posedge aclk) begin : watch
        frame_tally_t want;
        if (!aresetn) begin
            cols_reg      = gbc_pkg::RST_GRID_COLS;
            rows_reg      = gbc_pkg::RST_GRID_ROWS;
            threshold_reg = gbc_pkg::RST_PAIR_THRESHOLD;
            foreach (prior_row[i]) prior_row[i] = '0;
            left_nb       = '0;
            up_left_nb    = '0;
            col_at        = 0;
            row_at        = 0;
            running_tally = '0;
            fail_tally    = 0;
            match_tally   = 0;
            expected_tallies.delete();
        end else begin
            // register write
            if (psel && penable && pwrite && pready) begin
                case (gbc_pkg::reg_idx_t'(paddr[gbc_pkg::ADDR_W-1:2]))
                    gbc_pkg::REG_GRID_COLS:
                        cols_reg = pwdata[gbc_pkg::COLS_W-1:0];
                    gbc_pkg::REG_GRID_ROWS:
                        rows_reg = pwdata[gbc_pkg::ROWS_W-1:0];
                    gbc_pkg::REG_PAIR_THRESHOLD:
                        threshold_reg = pwdata[gbc_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            // result transfer against the oldest frame total
            if (m_valid && m_ready) begin
                if (expected_tallies.size() == 0) begin
                    $error("result transfer with no frame pending, pair_count %0d",
                           m_pair_count);
                    fail_tally++;
                end else begin
                    want = expected_tallies.pop_front();
                    match_tally++;
                    if (m_pair_count !== want.count) begin
                        $error("pair_count: expected %0d, got %0d", want.count, m_pair_count);
                        fail_tally++;
                    end
                    if (m_connected !== want.connected) begin
                        $error("connected: expected %0d, got %0d", want.connected,
                               m_connected);
                        fail_tally++;
                    end
                end
            end
            // cell transfer
            if (s_valid && s_ready) tally_cell(s_occupied, s_from_first, s_obstacle);
        end
        mismatches      <= fail_tally;
        tallies_pending <= expected_tallies.size();
        frames_checked  <= match_tally;
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_CELLS = 650;

    logic                        aclk         = 1'b0;
    logic                        aresetn      = 1'b0;
    logic                        psel         = 1'b0;
    logic                        penable      = 1'b0;
    logic                        pwrite       = 1'b0;
    logic [gbc_pkg::ADDR_W-1:0]  paddr        = '0;
    logic [gbc_pkg::DATA_W-1:0]  pwdata       = '0;
    logic [gbc_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        s_valid      = 1'b0;
    logic                        s_ready;
    logic                        s_occupied   = 1'b0;
    logic                        s_from_first = 1'b0;
    logic                        s_obstacle   = 1'b0;
    logic                        m_valid;
    logic                        m_ready      = 1'b1;
    logic [gbc_pkg::COUNT_W-1:0] m_pair_count;
    logic                        m_connected;

    int                 mismatches;
    int                 tallies_pending;
    int                 frames_checked;
    int unsigned        frame_cols;
    int unsigned        frame_rows;
    int unsigned        cells_sent;
    int unsigned        random_cells;
    int unsigned        ready_wait;
    int unsigned        cycle_count;
    logic               calm = 1'b0;

    grid_boundary_contact_counter dut (.*);

    contact_count_checker tally_check (.*);

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[grid_boundary_contact_counter] ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [gbc_pkg::COUNT_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return gbc_pkg::COUNT_MAX;
            default: return gbc_pkg::COUNT_W'($urandom_range(0, 60));
        endcase
    endfunction

    // result side backpressure, a fresh pause drawn after every transfer
    always @(posedge aclk) begin : rx_pace
        int unsigned pause;
        if (!aresetn) begin
            m_ready    <= 1'b1;
            ready_wait <= 0;
        end else if (m_valid && m_ready) begin
            pause = pick_gap();
            ready_wait <= pause;
            m_ready    <= (pause == 0);
        end else if (ready_wait != 0) begin
            ready_wait <= ready_wait - 1;
            m_ready    <= (ready_wait == 1);
        end
    end

    task automatic reg_write(input gbc_pkg::reg_idx_t idx,
                             input logic [gbc_pkg::DATA_W-1:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= gbc_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // one cell transfer; valid stays up when the next cell follows at once
    task automatic send_cell(input logic occ, input logic ff, input logic obs);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_occupied   <= occ;
        s_from_first <= ff;
        s_obstacle   <= obs;
        do @(posedge aclk); while (!s_ready);
        cells_sent++;
    endtask

    // new geometry and threshold, only once the block has drained
    task automatic configure(input int unsigned cols_val, input int unsigned rows_val,
                             input logic [gbc_pkg::COUNT_W-1:0] thr_val);
        s_valid <= 1'b0;
        do @(posedge aclk); while (tallies_pending != 0);
        repeat (8) @(posedge aclk);
        reg_write(gbc_pkg::REG_GRID_COLS, cols_val);
        reg_write(gbc_pkg::REG_GRID_ROWS, rows_val);
        reg_write(gbc_pkg::REG_PAIR_THRESHOLD, gbc_pkg::DATA_W'(thr_val));
        frame_cols = (cols_val == 0) ? 1 :
                     (cols_val > gbc_pkg::DEF_MAX_COLS) ? gbc_pkg::DEF_MAX_COLS : cols_val;
        frame_rows = (rows_val == 0) ? 1 :
                     (rows_val > gbc_pkg::DEF_MAX_ROWS) ? gbc_pkg::DEF_MAX_ROWS : rows_val;
    endtask

    // cells as octal digits {occupied, from_first, obstacle}, first cell leftmost
    task automatic play(input int unsigned count, input logic [47:0] codes);
        logic [2:0] code;
        for (int unsigned i = 0; i < count; i++) begin
            code = codes[3*(count-1-i) +: 3];
            send_cell(code[2], code[1], code[0]);
        end
    endtask

    // one whole frame with random density and a random map layout
    task automatic random_frame();
        int unsigned occ_pct;
        int unsigned obs_pct;
        int unsigned layout;
        logic        ff;
        occ_pct = $urandom_range(40, 100);
        obs_pct = $urandom_range(0, 25);
        layout  = $urandom_range(0, 2);
        for (int unsigned r = 0; r < frame_rows; r++) begin
            for (int unsigned c = 0; c < frame_cols; c++) begin
                case (layout)
                    0: ff = 1'($urandom_range(0, 1));
                    1: ff = ((r + c) % 2) != 0;
                    default: ff = (2 * c < frame_cols);
                endcase
                send_cell($urandom_range(1, 100) <= occ_pct, ff,
                          $urandom_range(1, 100) <= obs_pct);
            end
        end
    endtask

    initial begin : stimulus
        logic        reshape;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames: every cell kind, all four neighbour directions,
        // sizes of zero, threshold at both ends
        configure(3, 3, '0);
        play(9, 48'o646464215);
        configure(0, 2, gbc_pkg::COUNT_MAX);
        play(2, 48'o70);
        configure(2, 0, '0);
        play(2, 48'o36);
        configure(2, 2, 5);
        play(4, 48'o6446);
        configure(4, 2, 11);
        play(8, 48'o64644646);

        // random small frames, geometry often changed between frames
        reshape = 1'b1;
        while (random_cells < RANDOM_CELLS) begin
            calm = ($urandom_range(0, 3) == 0);
            if (reshape || $urandom_range(0, 2) != 0) begin
                configure($urandom_range(0, 9), $urandom_range(0, 6),
                          pick_threshold());
            end
            reshape = 1'b0;
            random_frame();
            random_cells += frame_cols * frame_rows;
        end

        // drain
        s_valid <= 1'b0;
        do @(posedge aclk); while (tallies_pending != 0);
        repeat (16) @(posedge aclk);
        $display("%0d cells in %0d checked frames, grids from 1x1 up to 9x6",
                 cells_sent, frames_checked);
        $display("zero sizes clamped to one, thresholds from zero to full scale");
        if (mismatches == 0) begin
            $display("[grid_boundary_contact_counter] OK");
        end else begin
            $display("[grid_boundary_contact_counter] ERROR");
        end
        $finish;
    end

endmodule

FILE: grid_boundary_contact_counter.f
rtl/gbc_pkg.sv
rtl/gbc_cfg.sv
rtl/gbc_line_buf.sv
rtl/gbc_tally.sv
rtl/grid_boundary_contact_counter.sv
bench/contact_count_checker.sv
bench/tb_top.sv
